@@ design/epr_pkg.sv @@
// Shared types and constants for the Euler point rotation block.
package epr_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIVOT_X = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIVOT_Y = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PIVOT_Z = 3'd5;

   // Binary angle: 16 bits per turn, Q14 quarter turn
   localparam int TURN_BITS = 16;
   localparam logic [TURN_BITS-1:0] QUARTER_TURN = 16'h4000;

   // Q1.15 sine/cosine
   localparam int TRIG_BITS = 16;
   localparam logic signed [TRIG_BITS-1:0] TRIG_MAX = 16'sd32767;

   // Odd polynomial coefficients, Q28
   localparam logic signed [31:0] CO1 = 32'sd421657428;
   localparam logic signed [31:0] CO3 = -32'sd173399667;
   localparam logic signed [31:0] CO5 = 32'sd21392326;
   localparam logic signed [31:0] CO7 = -32'sd1256749;
   localparam logic signed [31:0] CO9 = 32'sd43068;

   typedef struct packed {
      logic signed [TRIG_BITS-1:0] cos_q;
      logic signed [TRIG_BITS-1:0] sin_q;
   } trig_pair_type;

   // Horner coefficient after step n (highest order first)
   function automatic logic signed [31:0] horner_coef(input logic [1:0] step);
      logic signed [31:0] c;
      unique case (step)
         2'd0: c = CO7;
         2'd1: c = CO5;
         2'd2: c = CO3;
         2'd3: c = CO1;
         default: c = CO1;
      endcase
      return c;
   endfunction

endpackage

@@ design/epr_trig.sv @@
// Sequential sine/cosine generator for the three rotation angles.
module epr_trig import epr_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ANGLE_BITS-1:0] angle [3],
   output logic                  busy,
   output trig_pair_type         trig [3]
);

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_SETUP  = 8'b0000_0010,
      PH_SQUARE = 8'b0000_0100,
      PH_MUL_LO = 8'b0000_1000,
      PH_MUL_HI = 8'b0001_0000,
      PH_HORNER = 8'b0010_0000,
      PH_FINAL  = 8'b0100_0000,
      PH_ROUND  = 8'b1000_0000
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [2:0]          job_ff, job_in;      // {axis, cos}
   logic [1:0]          step_ff, step_in;
   logic [14:0]         t_ff;
   logic [28:0]         t2_ff;
   logic                neg_ff;
   logic signed [31:0]  acc_ff;
   logic signed [49:0]  plo_ff, phi_ff, prod_ff;
   trig_pair_type       trig_ff [3];

   logic signed [32:0]  mul_a;
   logic [15:0]         mul_b;
   logic signed [49:0]  mul_res;
   logic [ANGLE_BITS-1:0] angle_sel;
   logic [TURN_BITS-1:0]  ang16;
   logic [14:0]         t_new;
   logic signed [63:0]  hsum;
   logic signed [31:0]  acc_next;
   logic signed [49:0]  rsum, rnd;
   logic signed [TRIG_BITS-1:0] mag, res;

   // shared multiplier
   always_comb begin
      mul_a = 33'(acc_ff);
      mul_b = '0;
      unique case (phase_ff)
         PH_SQUARE: begin
            mul_a = $signed({18'b0, t_ff});
            mul_b = {1'b0, t_ff};
         end
         PH_MUL_LO: mul_b = {1'b0, t2_ff[14:0]};
         PH_MUL_HI: mul_b = {2'b0, t2_ff[28:15]};
         PH_FINAL:  mul_b = {1'b0, t_ff};
         default:   mul_b = '0;
      endcase
   end
   assign mul_res = mul_a * $signed({1'b0, mul_b});

   always_comb begin
      unique case (job_ff[2:1])
         2'd0:    angle_sel = angle[0];
         2'd1:    angle_sel = angle[1];
         2'd2:    angle_sel = angle[2];
         default: angle_sel = angle[0];
      endcase
      ang16 = TURN_BITS'(angle_sel) << (TURN_BITS - ANGLE_BITS);
      if (job_ff[0]) begin
         ang16 = ang16 + QUARTER_TURN;
      end
      // odd quadrants mirror about the quarter turn
      t_new = ang16[14] ? (15'(QUARTER_TURN) - {1'b0, ang16[13:0]}) : {1'b0, ang16[13:0]};
   end

   assign hsum     = (64'(phi_ff) <<< 15) + 64'(plo_ff);
   assign acc_next = horner_coef(step_ff) + 32'(hsum >>> 28);
   assign rsum     = prod_ff + 50'sd67108864;
   assign rnd      = rsum >>> 27;

   always_comb begin
      if (rnd < 0) begin
         mag = '0;
      end else if (rnd > 50'(TRIG_MAX)) begin
         mag = TRIG_MAX;
      end else begin
         mag = rnd[TRIG_BITS-1:0];
      end
      res = neg_ff ? -mag : mag;
   end

   always_comb begin
      phase_in = phase_ff;
      job_in   = job_ff;
      step_in  = step_ff;
      unique case (phase_ff)
         PH_IDLE:   phase_in = PH_IDLE;
         PH_SETUP: begin
            phase_in = PH_SQUARE;
            step_in  = '0;
         end
         PH_SQUARE: phase_in = PH_MUL_LO;
         PH_MUL_LO: phase_in = PH_MUL_HI;
         PH_MUL_HI: phase_in = PH_HORNER;
         PH_HORNER: begin
            step_in  = step_ff + 2'd1;
            phase_in = (step_ff == 2'd3) ? PH_FINAL : PH_MUL_LO;
         end
         PH_FINAL:  phase_in = PH_ROUND;
         PH_ROUND: begin
            if (job_ff == 3'd5) begin
               phase_in = PH_IDLE;
            end else begin
               job_in   = job_ff + 3'd1;
               phase_in = PH_SETUP;
            end
         end
         default:   phase_in = PH_IDLE;
      endcase
      if (start) begin
         phase_in = PH_SETUP;
         job_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SETUP;
         job_ff   <= '0;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         job_ff   <= job_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff == PH_SETUP) begin
         t_ff   <= t_new;
         neg_ff <= ang16[15];
         acc_ff <= CO9;
      end
      if (phase_ff == PH_SQUARE) begin
         t2_ff <= mul_res[28:0];
      end
      if (phase_ff == PH_MUL_LO) begin
         plo_ff <= mul_res;
      end
      if (phase_ff == PH_MUL_HI) begin
         phi_ff <= mul_res;
      end
      if (phase_ff == PH_HORNER) begin
         acc_ff <= acc_next;
      end
      if (phase_ff == PH_FINAL) begin
         prod_ff <= mul_res;
      end
      if (phase_ff == PH_ROUND) begin
         if (job_ff[0]) begin
            trig_ff[job_ff[2:1]].cos_q <= res;
         end else begin
            trig_ff[job_ff[2:1]].sin_q <= res;
         end
      end
   end

   assign busy = (phase_ff != PH_IDLE);
   assign trig = trig_ff;

endmodule

@@ design/epr_rot.sv @@
// One axis rotation: registered products, then registered sums.
module epr_rot import epr_pkg::*; #(
   parameter int COORD_W = 28
) (
   input  logic                      clock,
   input  logic                      reset,
   input  trig_pair_type             trig,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [COORD_W-1:0] in_a,
   input  logic signed [COORD_W-1:0] in_b,
   input  logic signed [COORD_W-1:0] in_p,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [COORD_W-1:0] out_a,
   output logic signed [COORD_W-1:0] out_b,
   output logic signed [COORD_W-1:0] out_p
);

   localparam int PROD_W = COORD_W + TRIG_BITS;

   logic                      v1_ff, v2_ff;
   logic                      rdy1, rdy2;
   logic signed [PROD_W-1:0]  ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [COORD_W-1:0] p1_ff;
   logic signed [PROD_W:0]    dif, sum;
   logic signed [COORD_W-1:0] a2_ff, b2_ff, p2_ff;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   // new a = a cos - b sin, new b = a sin + b cos, floor by 15
   assign dif = (PROD_W + 1)'(ac_ff) - (PROD_W + 1)'(bs_ff);
   assign sum = (PROD_W + 1)'(as_ff) + (PROD_W + 1)'(bc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         ac_ff <= in_a * trig.cos_q;
         bs_ff <= in_b * trig.sin_q;
         as_ff <= in_a * trig.sin_q;
         bc_ff <= in_b * trig.cos_q;
         p1_ff <= in_p;
      end
      if (rdy2 && v1_ff) begin
         a2_ff <= COORD_W'(dif >>> 15);
         b2_ff <= COORD_W'(sum >>> 15);
         p2_ff <= p1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_a     = a2_ff;
   assign out_b     = b2_ff;
   assign out_p     = p2_ff;

endmodule

@@ design/euler_point_rotation.sv @@
// Top level: rotates a vertex about a pivot, x then y then z axis.
// Stages: pivot subtract, three two-stage axis rotations, pivot add with
//   saturation. Throughput: one vertex per cycle unless rsp_ready or the
//   sine/cosine sequencer stalls; each axis has its own four multipliers.
// Reset (synchronous, active high) clears control and configuration state,
//   then the sequencer runs with req_ready low; each angle write reruns it.
module euler_point_rotation import epr_pkg::*; #(
   parameter int COORD_BITS = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // vertex input
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_z,
   // rotated output
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_rotated_x,
   output logic signed [COORD_BITS-1:0] rsp_rotated_y,
   output logic signed [COORD_BITS-1:0] rsp_rotated_z,
   output logic                         rsp_clipped,
   // configuration writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [((COORD_BITS > TURN_BITS) ? COORD_BITS : TURN_BITS)-1:0] csr_wdata
);

   // Internal coordinate width: headroom for pivot offset and axis growth.
   localparam int W = COORD_BITS + 4;

   logic [ANGLE_BITS-1:0]        angle_ff [3];
   logic signed [COORD_BITS-1:0] pivot_ff [3];
   logic                         csr_write;
   logic                         angle_start;
   logic                         trig_busy;
   trig_pair_type                trig [3];

   // front stage: vertex minus pivot
   logic                s0_valid_ff, s0_ready;
   logic signed [W-1:0] s0_x_ff, s0_y_ff, s0_z_ff;

   // rotation chain
   logic                rx_in_ready, rx_valid, ry_in_ready, ry_valid;
   logic                rz_in_ready, rz_valid;
   logic signed [W-1:0] rx_y, rx_z, rx_x;
   logic signed [W-1:0] ry_x, ry_z, ry_y;
   logic signed [W-1:0] rz_y, rz_x, rz_z;

   // output stage
   logic                          out_ready;
   logic                          rsp_valid_ff;
   logic signed [COORD_BITS-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                          rsp_clip_ff;
   logic [COORD_BITS:0]           sat_x, sat_y, sat_z;

   // {clip, value}: clamp a wide value into COORD_BITS signed
   function automatic logic [COORD_BITS:0] saturate(input logic signed [W-1:0] v);
      logic [W-COORD_BITS:0] top;
      logic                  fits;
      top  = v[W-1:COORD_BITS-1];
      fits = (top == '0) || (top == '1);
      if (fits) begin
         return {1'b0, v[COORD_BITS-1:0]};
      end
      return {1'b1, v[W-1], {(COORD_BITS-1){!v[W-1]}}};
   endfunction

   // ---------------- configuration ----------------
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign angle_start = csr_write &&
      ((csr_index == CSR_ANGLE_X) || (csr_index == CSR_ANGLE_Y) ||
       (csr_index == CSR_ANGLE_Z));

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '{default: '0};
         pivot_ff <= '{default: '0};
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ANGLE_X: angle_ff[0] <= csr_wdata[TURN_BITS-1 -: ANGLE_BITS];
            CSR_ANGLE_Y: angle_ff[1] <= csr_wdata[TURN_BITS-1 -: ANGLE_BITS];
            CSR_ANGLE_Z: angle_ff[2] <= csr_wdata[TURN_BITS-1 -: ANGLE_BITS];
            CSR_PIVOT_X: pivot_ff[0] <= $signed(csr_wdata[COORD_BITS-1:0]);
            CSR_PIVOT_Y: pivot_ff[1] <= $signed(csr_wdata[COORD_BITS-1:0]);
            CSR_PIVOT_Z: pivot_ff[2] <= $signed(csr_wdata[COORD_BITS-1:0]);
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // sine/cosine for all three angles, recomputed after any angle write
   epr_trig #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_trig (
      .clock (clock),
      .reset (reset),
      .start (angle_start),
      .angle (angle_ff),
      .busy  (trig_busy),
      .trig  (trig)
   );

   // ---------------- front stage ----------------
   assign s0_ready  = !s0_valid_ff || rx_in_ready;
   assign req_ready = s0_ready && !trig_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid && !trig_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_x_ff <= W'(req_vertex_x) - W'(pivot_ff[0]);
         s0_y_ff <= W'(req_vertex_y) - W'(pivot_ff[1]);
         s0_z_ff <= W'(req_vertex_z) - W'(pivot_ff[2]);
      end
   end

   // ---------------- axis rotations ----------------
   // about x: (y, z) rotate, x passes
   epr_rot #(.COORD_W(W)) u_rot_x (
      .clock     (clock),
      .reset     (reset),
      .trig      (trig[0]),
      .in_valid  (s0_valid_ff),
      .in_ready  (rx_in_ready),
      .in_a      (s0_y_ff),
      .in_b      (s0_z_ff),
      .in_p      (s0_x_ff),
      .out_valid (rx_valid),
      .out_ready (ry_in_ready),
      .out_a     (rx_y),
      .out_b     (rx_z),
      .out_p     (rx_x)
   );

   // about y: (x, z) rotate, y passes
   epr_rot #(.COORD_W(W)) u_rot_y (
      .clock     (clock),
      .reset     (reset),
      .trig      (trig[1]),
      .in_valid  (rx_valid),
      .in_ready  (ry_in_ready),
      .in_a      (rx_x),
      .in_b      (rx_z),
      .in_p      (rx_y),
      .out_valid (ry_valid),
      .out_ready (rz_in_ready),
      .out_a     (ry_x),
      .out_b     (ry_z),
      .out_p     (ry_y)
   );

   // about z: new y = y cos - x sin, new x = y sin + x cos
   epr_rot #(.COORD_W(W)) u_rot_z (
      .clock     (clock),
      .reset     (reset),
      .trig      (trig[2]),
      .in_valid  (ry_valid),
      .in_ready  (rz_in_ready),
      .in_a      (ry_y),
      .in_b      (ry_x),
      .in_p      (ry_z),
      .out_valid (rz_valid),
      .out_ready (out_ready),
      .out_a     (rz_y),
      .out_b     (rz_x),
      .out_p     (rz_z)
   );

   // ---------------- pivot add, saturate, output register ----------------
   assign sat_x     = saturate(rz_x + W'(pivot_ff[0]));
   assign sat_y     = saturate(rz_y + W'(pivot_ff[1]));
   assign sat_z     = saturate(rz_z + W'(pivot_ff[2]));
   assign out_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= rz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && rz_valid) begin
         rsp_x_ff    <= sat_x[COORD_BITS-1:0];
         rsp_y_ff    <= sat_y[COORD_BITS-1:0];
         rsp_z_ff    <= sat_z[COORD_BITS-1:0];
         rsp_clip_ff <= sat_x[COORD_BITS] || sat_y[COORD_BITS] || sat_z[COORD_BITS];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rotated_x = rsp_x_ff;
   assign rsp_rotated_y = rsp_y_ff;
   assign rsp_rotated_z = rsp_z_ff;
   assign rsp_clipped   = rsp_clip_ff;

endmodule

@@ design/epr_checker.sv @@
// Port-level checks for the Euler point rotation block, with its bind.
module epr_checker import epr_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         csr_valid,
   input logic                         csr_ready,
   input logic [CSR_INDEX_BITS-1:0]    csr_index,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_rotated_x,
   input logic signed [COORD_BITS-1:0] rsp_rotated_y,
   input logic signed [COORD_BITS-1:0] rsp_rotated_z,
   input logic                         rsp_clipped
);

   localparam logic signed [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before transfer");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_rotated_x) && $stable(rsp_rotated_y) &&
         $stable(rsp_rotated_z) && $stable(rsp_clipped))
      else $error("rsp payload changed while stalled");

   // trig tables are rebuilt right after reset
   a_reset_block: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("input taken before trig tables were built");

   // an angle write drops req_ready as the table rebuild begins
   a_angle_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready &&
      (csr_index == CSR_ANGLE_X || csr_index == CSR_ANGLE_Y || csr_index == CSR_ANGLE_Z)
      |=> !req_ready)
      else $error("input taken right after angle write");

   // clipping implies some coordinate sits at a rail
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_rotated_x == MAXV || rsp_rotated_x == MINV ||
         rsp_rotated_y == MAXV || rsp_rotated_y == MINV ||
         rsp_rotated_z == MAXV || rsp_rotated_z == MINV)
      else $error("clipped flagged with no saturated coordinate");

endmodule

bind euler_point_rotation epr_checker #(.COORD_BITS(COORD_BITS)) u_epr_checker (.*);
